### rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// shared widths, stage counts and item types of the segment crossing pipeline
// ----------------------------------------------------------------------------
package sip_pkg;

	localparam int COORD_BITS = 16;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int LINE_W = 2 * COORD_BITS + 2;
	localparam int LO_W   = DIFF_W;
	localparam int HI_W   = LINE_W - LO_W;
	localparam int NUM_W  = DIFF_W + LINE_W + 1;
	localparam int DET_W  = SUM_W;
	localparam int QUO_W  = COORD_BITS + 1;
	localparam int DIV_W  = NUM_W + 2;

	localparam int FRONT_ST = 3;
	localparam int NUMER_ST = 4;
	localparam int DIV_ST   = QUO_W + 2;
	localparam int NSTAGE   = FRONT_ST + NUMER_ST + DIV_ST + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic signed [LINE_W-1:0]     line_t;
	typedef logic signed [NUM_W-1:0]      num_t;

	typedef struct packed {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_end_x;
		coord_t b_end_y;
	} in_item_t;

	typedef struct packed {
		logic   hit;
		coord_t cross_x;
		coord_t cross_y;
	} out_item_t;

	typedef struct packed {
		diff_t la;
		diff_t lb;
		diff_t ma;
		diff_t mb;
		line_t lc;
		line_t mc;
		sum_t  det;
		logic  hit;
	} front_t;

	typedef struct packed {
		logic [NUM_W-1:0] mag;
		logic [DET_W-1:0] den;
		logic             neg;
	} div_in_t;

	typedef struct packed {
		logic [QUO_W:0] quo;
		logic           neg;
	} div_out_t;

endpackage

### rtl/sip_if.sv
// ----------------------------------------------------------------------------
// sip_in_if / sip_out_if
// valid/ready channels carrying segment pairs in and crossing results out
// ----------------------------------------------------------------------------
interface sip_in_if;
	import sip_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sip_out_if;
	import sip_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/sip_front.sv
// ----------------------------------------------------------------------------
// sip_front
// differences, cross products, line coefficients and crossing test
// ----------------------------------------------------------------------------
module sip_front (
	input  logic                            clk,
	input  logic [sip_pkg::FRONT_ST-1:0]    en,
	input  sip_pkg::in_item_t               item,
	output sip_pkg::front_t                 res
);
	import sip_pkg::*;

	function automatic diff_t sub(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	function automatic logic opposite(sum_t a, sum_t b);
		return (a > 0 && b < 0) || (a < 0 && b > 0);
	endfunction

	diff_t  la_s1, lb_s1, ma_s1, mb_s1;
	diff_t  d1x_s1, d1y_s1, d2x_s1, d2y_s1;
	diff_t  e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	coord_t p1x_s1, p1y_s1, q1x_s1, q1y_s1;

	prod_t k1a_s2, k1b_s2, k2a_s2, k2b_s2;
	prod_t j1a_s2, j1b_s2, j2a_s2, j2b_s2;
	prod_t dla_s2, dlb_s2, lca_s2, lcb_s2, mca_s2, mcb_s2;
	diff_t la_s2, lb_s2, ma_s2, mb_s2;

	sum_t  sq1, sq2, sp1, sp2;
	front_t res_s3;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			la_s1  <= sub(item.a_end_y, item.a_start_y);
			lb_s1  <= sub(item.a_start_x, item.a_end_x);
			ma_s1  <= sub(item.b_end_y, item.b_start_y);
			mb_s1  <= sub(item.b_start_x, item.b_end_x);
			d1x_s1 <= sub(item.b_start_x, item.a_start_x);
			d1y_s1 <= sub(item.b_start_y, item.a_start_y);
			d2x_s1 <= sub(item.b_end_x, item.a_start_x);
			d2y_s1 <= sub(item.b_end_y, item.a_start_y);
			e1x_s1 <= sub(item.a_start_x, item.b_start_x);
			e1y_s1 <= sub(item.a_start_y, item.b_start_y);
			e2x_s1 <= sub(item.a_end_x, item.b_start_x);
			e2y_s1 <= sub(item.a_end_y, item.b_start_y);
			p1x_s1 <= item.a_start_x;
			p1y_s1 <= item.a_start_y;
			q1x_s1 <= item.b_start_x;
			q1y_s1 <= item.b_start_y;
		end
		if (en[1]) begin
			k1a_s2 <= d1x_s1 * la_s1;
			k1b_s2 <= d1y_s1 * lb_s1;
			k2a_s2 <= d2x_s1 * la_s1;
			k2b_s2 <= d2y_s1 * lb_s1;
			j1a_s2 <= e1x_s1 * ma_s1;
			j1b_s2 <= e1y_s1 * mb_s1;
			j2a_s2 <= e2x_s1 * ma_s1;
			j2b_s2 <= e2y_s1 * mb_s1;
			dla_s2 <= la_s1 * mb_s1;
			dlb_s2 <= ma_s1 * lb_s1;
			lca_s2 <= la_s1 * p1x_s1;
			lcb_s2 <= lb_s1 * p1y_s1;
			mca_s2 <= ma_s1 * q1x_s1;
			mcb_s2 <= mb_s1 * q1y_s1;
			la_s2  <= la_s1;
			lb_s2  <= lb_s1;
			ma_s2  <= ma_s1;
			mb_s2  <= mb_s1;
		end
		if (en[2]) begin
			res_s3.la  <= la_s2;
			res_s3.lb  <= lb_s2;
			res_s3.ma  <= ma_s2;
			res_s3.mb  <= mb_s2;
			res_s3.lc  <= line_t'(lca_s2) + line_t'(lcb_s2);
			res_s3.mc  <= line_t'(mca_s2) + line_t'(mcb_s2);
			res_s3.det <= sum_t'(dla_s2) - sum_t'(dlb_s2);
			res_s3.hit <= opposite(sq1, sq2) && opposite(sp1, sp2);
		end
	end

	always_comb begin
		sq1 = sum_t'(k1a_s2) + sum_t'(k1b_s2);
		sq2 = sum_t'(k2a_s2) + sum_t'(k2b_s2);
		sp1 = sum_t'(j1a_s2) + sum_t'(j1b_s2);
		sp2 = sum_t'(j2a_s2) + sum_t'(j2b_s2);
	end

	assign res = res_s3;

endmodule

### rtl/sip_numer.sv
// ----------------------------------------------------------------------------
// sip_numer
// cramer numerators from split partial products, then magnitudes and signs
// ----------------------------------------------------------------------------
module sip_numer (
	input  logic                            clk,
	input  logic [sip_pkg::NUMER_ST-1:0]    en,
	input  sip_pkg::front_t                 fr,
	output sip_pkg::div_in_t                div_x,
	output sip_pkg::div_in_t                div_y,
	output logic                            hit
);
	import sip_pkg::*;

	localparam int HP_W = DIFF_W + HI_W;
	localparam int LP_W = DIFF_W + LO_W + 1;

	logic signed [HI_W-1:0] lch, mch;
	logic signed [LO_W:0]   lcl, mcl;

	logic signed [HP_W-1:0] mb_lch_s4, lb_mch_s4, la_mch_s4, ma_lch_s4;
	logic signed [LP_W-1:0] mb_lcl_s4, lb_mcl_s4, la_mcl_s4, ma_lcl_s4;
	sum_t                   det_s4, det_s5, det_s6;
	logic                   hit_s4, hit_s5, hit_s6, hit_s7;

	logic [HP_W:0] hx_s5, hy_s5;
	logic [LP_W:0] lx_s5, ly_s5;

	logic [NUM_W-1:0] nx_s6, ny_s6;
	logic [DET_W-1:0] dd;

	div_in_t dx_s7, dy_s7;

	assign lch = fr.lc[LINE_W-1:LO_W];
	assign mch = fr.mc[LINE_W-1:LO_W];
	assign lcl = $signed({1'b0, fr.lc[LO_W-1:0]});
	assign mcl = $signed({1'b0, fr.mc[LO_W-1:0]});
	assign dd  = det_s6;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mb_lch_s4 <= fr.mb * lch;
			lb_mch_s4 <= fr.lb * mch;
			la_mch_s4 <= fr.la * mch;
			ma_lch_s4 <= fr.ma * lch;
			mb_lcl_s4 <= fr.mb * lcl;
			lb_mcl_s4 <= fr.lb * mcl;
			la_mcl_s4 <= fr.la * mcl;
			ma_lcl_s4 <= fr.ma * lcl;
			det_s4    <= fr.det;
			hit_s4    <= fr.hit && (fr.det != '0);
		end
		if (en[1]) begin
			hx_s5  <= {mb_lch_s4[HP_W-1], mb_lch_s4} - {lb_mch_s4[HP_W-1], lb_mch_s4};
			hy_s5  <= {la_mch_s4[HP_W-1], la_mch_s4} - {ma_lch_s4[HP_W-1], ma_lch_s4};
			lx_s5  <= {mb_lcl_s4[LP_W-1], mb_lcl_s4} - {lb_mcl_s4[LP_W-1], lb_mcl_s4};
			ly_s5  <= {la_mcl_s4[LP_W-1], la_mcl_s4} - {ma_lcl_s4[LP_W-1], ma_lcl_s4};
			det_s5 <= det_s4;
			hit_s5 <= hit_s4;
		end
		if (en[2]) begin
			nx_s6  <= {hx_s5, {LO_W{1'b0}}} + {{(NUM_W-LP_W-1){lx_s5[LP_W]}}, lx_s5};
			ny_s6  <= {hy_s5, {LO_W{1'b0}}} + {{(NUM_W-LP_W-1){ly_s5[LP_W]}}, ly_s5};
			det_s6 <= det_s5;
			hit_s6 <= hit_s5;
		end
		if (en[3]) begin
			dx_s7.mag <= nx_s6[NUM_W-1] ? (~nx_s6 + 1'b1) : nx_s6;
			dy_s7.mag <= ny_s6[NUM_W-1] ? (~ny_s6 + 1'b1) : ny_s6;
			dx_s7.den <= dd[DET_W-1] ? (~dd + 1'b1) : dd;
			dy_s7.den <= dd[DET_W-1] ? (~dd + 1'b1) : dd;
			dx_s7.neg <= nx_s6[NUM_W-1] ^ dd[DET_W-1];
			dy_s7.neg <= ny_s6[NUM_W-1] ^ dd[DET_W-1];
			hit_s7    <= hit_s6;
		end
	end

	assign div_x = dx_s7;
	assign div_y = dy_s7;
	assign hit   = hit_s7;

endmodule

### rtl/sip_div.sv
// ----------------------------------------------------------------------------
// sip_div
// pipelined restoring divider, one quotient bit per stage, rounding to nearest
// ----------------------------------------------------------------------------
module sip_div (
	input  logic                          clk,
	input  logic [sip_pkg::DIV_ST-1:0]    en,
	input  sip_pkg::div_in_t              din,
	output sip_pkg::div_out_t             dout
);
	import sip_pkg::*;

	logic [DIV_W-1:0] rem_s [0:DIV_ST-2];
	logic [DIV_W-1:0] den_s [0:DIV_ST-2];
	logic [QUO_W:0]   quo_s [0:DIV_ST-1];
	logic             neg_s [0:DIV_ST-1];

	// rounding folded in: (2n + d) / (2d)
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= DIV_W'({din.mag, 1'b0}) + DIV_W'(din.den);
			den_s[0] <= DIV_W'({din.den, 1'b0});
			quo_s[0] <= '0;
			neg_s[0] <= din.neg;
		end
	end

	for (genvar k = 1; k < DIV_ST; k++) begin : g_bit
		localparam int B = QUO_W + 1 - k;
		logic [DIV_W-1:0] t;
		logic             ge;
		assign t  = den_s[k-1] << B;
		assign ge = rem_s[k-1] >= t;
		always_ff @(posedge clk) begin
			if (en[k]) begin
				quo_s[k] <= quo_s[k-1] | ((QUO_W+1)'(ge) << B);
				neg_s[k] <= neg_s[k-1];
			end
		end
		if (k < DIV_ST - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= ge ? (rem_s[k-1] - t) : rem_s[k-1];
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign dout.quo = quo_s[DIV_ST-1];
	assign dout.neg = neg_s[DIV_ST-1];

endmodule

### rtl/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// segment_intersection_point
// stages: 3 product, 4 numerator, 19 divider, 1 output register
// throughput: one item per cycle while the output is ready; every stage
//   has its own valid bit and advances when it is empty or its successor
//   moves, so bubbles close up
// reset: arst_n clears all valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
module segment_intersection_point (
	input  logic       clk,
	input  logic       arst_n,
	sip_in_if.sink     seg_in,
	sip_out_if.source  seg_out
);
	import sip_pkg::*;

	localparam int DIV_BASE = FRONT_ST + NUMER_ST;
	localparam logic [QUO_W:0] POS_LIM = {3'b000, {(COORD_BITS-1){1'b1}}};
	localparam logic [QUO_W:0] NEG_LIM = {2'b00, 1'b1, {(COORD_BITS-1){1'b0}}};

	function automatic coord_t saturate(logic [QUO_W:0] q, logic neg);
		logic [COORD_BITS-1:0] m;
		m = q[COORD_BITS-1:0];
		if (neg) begin
			if (q > NEG_LIM)
				return coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});
			return coord_t'(-m);
		end
		if (q > POS_LIM)
			return coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
		return coord_t'(m);
	endfunction

	logic [NSTAGE:1]   valid_s;
	logic [NSTAGE+1:1] en;
	logic [NSTAGE:1]   valid_prev;

	front_t    fr;
	div_in_t   div_x, div_y;
	div_out_t  qx, qy;
	logic      hit_n;
	logic      hit_s [0:DIV_ST-1];
	out_item_t result_q;

	always_comb begin
		en[NSTAGE+1] = seg_out.ready;
		for (int k = NSTAGE; k >= 1; k--)
			en[k] = ~valid_s[k] | en[k+1];
	end

	assign valid_prev = {valid_s[NSTAGE-1:1], seg_in.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int k = 1; k <= NSTAGE; k++)
				if (en[k])
					valid_s[k] <= valid_prev[k];
		end
	end

	sip_front u_front (
		.clk  (clk),
		.en   (en[FRONT_ST:1]),
		.item (seg_in.data),
		.res  (fr)
	);

	sip_numer u_numer (
		.clk   (clk),
		.en    (en[DIV_BASE:FRONT_ST+1]),
		.fr    (fr),
		.div_x (div_x),
		.div_y (div_y),
		.hit   (hit_n)
	);

	sip_div u_div_x (
		.clk  (clk),
		.en   (en[DIV_BASE+DIV_ST:DIV_BASE+1]),
		.din  (div_x),
		.dout (qx)
	);

	sip_div u_div_y (
		.clk  (clk),
		.en   (en[DIV_BASE+DIV_ST:DIV_BASE+1]),
		.din  (div_y),
		.dout (qy)
	);

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_ST; j++)
			if (en[DIV_BASE+1+j])
				hit_s[j] <= (j == 0) ? hit_n : hit_s[(j == 0) ? 0 : j-1];
		if (en[NSTAGE]) begin
			result_q.hit     <= hit_s[DIV_ST-1];
			result_q.cross_x <= hit_s[DIV_ST-1] ? saturate(qx.quo, qx.neg) : '0;
			result_q.cross_y <= hit_s[DIV_ST-1] ? saturate(qy.quo, qy.neg) : '0;
		end
	end

	assign seg_in.ready  = en[1];
	assign seg_out.valid = valid_s[NSTAGE];
	assign seg_out.data  = result_q;

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		seg_out.valid && !seg_out.data.hit |->
			seg_out.data.cross_x == '0 && seg_out.data.cross_y == '0)
		else $error("result without hit carries a nonzero point");

	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		seg_out.ready |-> seg_in.ready)
		else $error("input stalled while output drains");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(valid_s) == NSTAGE) && !seg_out.ready |-> !seg_in.ready)
		else $error("full pipeline accepted an item under stall");
`endif

endmodule

### verif/tb_segment_intersection_point.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection_point
// drives segment pairs into the crossing pipeline with random idling on both
// sides and checks every result against a local crossing-point predictor
// ----------------------------------------------------------------------------
module tb_segment_intersection_point;
	timeunit 1ns;
	timeprecision 1ps;
	import sip_pkg::*;

	localparam int LATENCY = 27;
	localparam int CYCLE_LIMIT = 400000;

	class crossing_board;
		out_item_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		static function longint side_sign(longint ox, longint oy, longint ex, longint ey,
			longint px, longint py);
			longint v;
			v = (px - ox) * (ey - oy) - (py - oy) * (ex - ox);
			return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
		endfunction

		static function bit opposite(longint s1, longint s2);
			return (s1 == 1 && s2 == -1) || (s1 == -1 && s2 == 1);
		endfunction

		static function coord_t round_sat(longint num, longint den);
			bit neg;
			longint un, ud, q;
			neg = (num < 0) != (den < 0);
			un = num < 0 ? -num : num;
			ud = den < 0 ? -den : den;
			q = (2 * un + ud) / (2 * ud);
			if (neg) begin
				if (q > 32768) q = 32768;
				return coord_t'(-q);
			end
			if (q > 32767) q = 32767;
			return coord_t'(q);
		endfunction

		function void note_pair(in_item_t s);
			longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
			longint la, lb, lc, ma, mb, mc, det;
			out_item_t r;
			p1x = s.a_start_x; p1y = s.a_start_y; p2x = s.a_end_x; p2y = s.a_end_y;
			q1x = s.b_start_x; q1y = s.b_start_y; q2x = s.b_end_x; q2y = s.b_end_y;
			r = '0;
			r.hit = opposite(side_sign(p1x, p1y, p2x, p2y, q1x, q1y),
					side_sign(p1x, p1y, p2x, p2y, q2x, q2y))
				&& opposite(side_sign(q1x, q1y, q2x, q2y, p1x, p1y),
					side_sign(q1x, q1y, q2x, q2y, p2x, p2y));
			if (r.hit) begin
				la = p2y - p1y; lb = p1x - p2x; lc = la * p1x + lb * p1y;
				ma = q2y - q1y; mb = q1x - q2x; mc = ma * q1x + mb * q1y;
				det = la * mb - ma * lb;
				if (det == 0) begin
					r.hit = 1'b0;
				end else begin
					r.cross_x = round_sat(mb * lc - lb * mc, det);
					r.cross_y = round_sat(la * mc - ma * lc, det);
				end
			end
			pending = {pending, r};
		endfunction

		task automatic report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task automatic check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report("result with no item pending");
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit)
				report($sformatf("hit got %b want %b", got.hit, want.hit));
			if (got.cross_x !== want.cross_x)
				report($sformatf("cross_x got %0d want %0d", got.cross_x, want.cross_x));
			if (got.cross_y !== want.cross_y)
				report($sformatf("cross_y got %0d want %0d", got.cross_y, want.cross_y));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int cycles;
	int send_idle, recv_idle;
	crossing_board board;

	sip_in_if seg_in ();
	sip_out_if seg_out ();

	segment_intersection_point DUT (
		.clk(clk),
		.arst_n(arst_n),
		.seg_in(seg_in.sink),
		.seg_out(seg_out.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		seg_in.valid = 1'b0;
		seg_in.data = '0;
		seg_out.ready = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		board = new();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (seg_out.valid && seg_out.ready)
			board.check_result(seg_out.data);
		if (arst_n)
			seg_out.ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_pair(in_item_t s);
		while ($urandom_range(99) < send_idle) begin
			seg_in.valid <= 1'b0;
			@(posedge clk);
		end
		seg_in.valid <= 1'b1;
		seg_in.data <= s;
		do
			@(posedge clk);
		while (!seg_in.ready);
		board.note_pair(s);
	endtask

	function automatic coord_t any_coord();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return coord_t'($urandom_range(2047) - 1024);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t crossing_pair();
		in_item_t s;
		int c, cy, sp;
		sp = ($urandom_range(3) == 0) ? 32767 : ($urandom_range(1) ? 2000 : 200);
		c = $urandom_range(2 * sp) - sp;
		cy = $urandom_range(2 * sp) - sp;
		s.a_start_x = coord_t'(c - int'($urandom_range(sp)));
		s.a_end_x = coord_t'(c + int'($urandom_range(sp)));
		s.a_start_y = coord_t'(cy - int'($urandom_range(sp)) + int'($urandom_range(sp)));
		s.a_end_y = coord_t'(cy - int'($urandom_range(sp)) + int'($urandom_range(sp)));
		s.b_start_y = coord_t'(cy - int'($urandom_range(sp)));
		s.b_end_y = coord_t'(cy + int'($urandom_range(sp)));
		s.b_start_x = coord_t'(c - int'($urandom_range(sp)) + int'($urandom_range(sp)));
		s.b_end_x = coord_t'(c - int'($urandom_range(sp)) + int'($urandom_range(sp)));
		if ($urandom_range(1)) begin
			{s.a_start_x, s.a_start_y, s.a_end_x, s.a_end_y} =
				{s.a_end_x, s.a_end_y, s.a_start_x, s.a_start_y};
		end
		return s;
	endfunction

	task automatic directed_pairs();
		in_item_t s;
		// plain cross at origin, x shape
		s = {16'sd0, -16'sd256, 16'sd0, 16'sd256, -16'sd256, 16'sd0, 16'sd256, 16'sd0};
		send_pair(s);
		s = {-16'sd256, -16'sd256, 16'sd256, 16'sd256, -16'sd256, 16'sd256, 16'sd256, -16'sd256};
		send_pair(s);
		// touching: endpoint on the other segment
		s = {16'sd0, -16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd256, 16'sd0};
		send_pair(s);
		// collinear overlap
		s = {16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd256, 16'sd0, 16'sd768, 16'sd0};
		send_pair(s);
		// parallel
		s = {16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd0, 16'sd10, 16'sd512, 16'sd10};
		send_pair(s);
		// degenerate segment
		s = {16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd10, 16'sd10};
		send_pair(s);
		// apart, no crossing
		s = {16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd20, -16'sd5, 16'sd20, 16'sd5};
		send_pair(s);
		// rounding of fractional points, both signs
		s = {16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd2};
		send_pair(s);
		s = {16'sd0, 16'sd0, -16'sd3, -16'sd1, -16'sd1, 16'sd1, -16'sd1, -16'sd2};
		send_pair(s);
		// extremes of the range
		s = {16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
		send_pair(s);
		s = {16'sh8000, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sh7fff};
		send_pair(s);
		s = {16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};
		send_pair(s);
		s = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
		send_pair(s);
		s = '1;
		send_pair(s);
		s = '0;
		send_pair(s);
		// near-parallel long segments, crossing on a rounding tie in x
		s = {16'sh8000, -16'sd1, 16'sh7fff, 16'sd1, 16'sh8000, 16'sd1, 16'sh7fff, -16'sd1};
		send_pair(s);
	endtask

	task automatic random_pairs(int count);
		in_item_t s;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 65) begin
				s = crossing_pair();
			end else begin
				s = {any_coord(), any_coord(), any_coord(), any_coord(),
					any_coord(), any_coord(), any_coord(), any_coord()};
			end
			send_pair(s);
		end
	endtask

	initial begin
		cycles = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 23;
		recv_idle = 58;
		directed_pairs();
		random_pairs(260);
		send_idle = 58;
		recv_idle = 23;
		random_pairs(270);
		send_idle = 0;
		recv_idle = 0;
		random_pairs(270);
		seg_in.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
